// File: sv/bmhq_pkg.sv
package bmhq_pkg;

	localparam int DATA_W  = 32;
	localparam int TOTAL_W = 7;
	localparam int OUT_W   = 72;
	localparam int PAD_W   = OUT_W - 2 * DATA_W - TOTAL_W;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_POP_EMPTY = 2'd1,
		STATUS_PUSH_FULL = 2'd2
	} status_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

endpackage

// File: sv/bmhq_store.sv
module bmhq_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [bmhq_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]                    raddr_a,
	input  logic [AW-1:0]                    raddr_b,
	output logic signed [bmhq_pkg::DATA_W-1:0] rdata_a,
	output logic signed [bmhq_pkg::DATA_W-1:0] rdata_b
);
	import bmhq_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: sv/bmhq_cmp.sv
module bmhq_cmp (
	input  logic signed [bmhq_pkg::DATA_W-1:0] lhs,
	input  logic signed [bmhq_pkg::DATA_W-1:0] rhs,
	output logic                               gt
);
	import bmhq_pkg::*;

	// signed strict greater-than, shared by every sift step
	assign gt = lhs > rhs;

endmodule

// File: sv/bmhq_ctrl.sv
module bmhq_ctrl #(
	parameter int CAPACITY = 64,
	parameter int AW       = 6,
	parameter int CW       = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic signed [bmhq_pkg::DATA_W-1:0] in_value,
	input  logic                               in_cmd,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic signed [bmhq_pkg::DATA_W-1:0] out_popped,
	output logic signed [bmhq_pkg::DATA_W-1:0] out_top,
	output logic [bmhq_pkg::TOTAL_W-1:0]       out_total,
	output bmhq_pkg::status_t                  out_status,
	output logic                               we,
	output logic [AW-1:0]                      waddr,
	output logic signed [bmhq_pkg::DATA_W-1:0] wdata,
	output logic [AW-1:0]                      raddr_a,
	output logic [AW-1:0]                      raddr_b,
	input  logic signed [bmhq_pkg::DATA_W-1:0] rdata_a,
	input  logic signed [bmhq_pkg::DATA_W-1:0] rdata_b,
	output logic signed [bmhq_pkg::DATA_W-1:0] cmp_lhs,
	output logic signed [bmhq_pkg::DATA_W-1:0] cmp_rhs,
	input  logic                               cmp_gt
);
	import bmhq_pkg::*;

	localparam int IW = AW + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_RD,
		ST_PUSH_CMP,
		ST_POP_LD,
		ST_DN_RD,
		ST_DN_CH,
		ST_DN_CMP,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            cnt_q;
	logic [AW-1:0]            pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] pick_q;
	logic [AW-1:0]            pick_idx_q;
	logic                     r_ok_q;
	logic signed [DATA_W-1:0] popped_q;
	logic signed [DATA_W-1:0] top_q;
	status_t                  status_q;

	logic [AW-1:0] parent;
	logic [AW-1:0] last_addr;
	logic [IW-1:0] l_ext;
	logic [IW-1:0] r_ext;
	logic [IW-1:0] cnt_ext;
	logic          l_ok;
	logic          r_ok;
	logic [AW-1:0] l_addr;
	logic [AW-1:0] r_addr;
	logic          out_free;

	assign parent    = AW'((pos_q - AW'(1)) >> 1);
	assign last_addr = AW'(cnt_q - CW'(1));
	assign l_ext     = {1'b0, pos_q, 1'b1};
	assign r_ext     = l_ext + IW'(1);
	assign cnt_ext   = IW'(cnt_q);
	assign l_ok      = l_ext < cnt_ext;
	assign r_ok      = r_ext < cnt_ext;
	assign l_addr    = l_ext[AW-1:0];
	assign r_addr    = r_ext[AW-1:0];
	assign out_free  = !m_tvalid || m_tready;
	assign s_tready  = state_q == ST_IDLE;

	// store access and comparator operand select
	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = val_q;
		raddr_a = parent;
		raddr_b = l_addr;
		cmp_lhs = pick_q;
		cmp_rhs = val_q;
		case (state_q)
			ST_IDLE: begin
				raddr_a = '0;
				raddr_b = last_addr;
			end
			ST_PUSH_RD: begin
				we = pos_q == '0;
			end
			ST_PUSH_CMP: begin
				cmp_lhs = val_q;
				cmp_rhs = rdata_a;
				we      = 1'b1;
				if (cmp_gt) begin
					wdata = rdata_a;
				end
			end
			ST_DN_RD: begin
				raddr_a = l_addr;
				raddr_b = r_ok ? r_addr : l_addr;
				we      = !l_ok;
			end
			ST_DN_CH: begin
				cmp_lhs = rdata_b;
				cmp_rhs = rdata_a;
			end
			ST_DN_CMP: begin
				we = 1'b1;
				if (cmp_gt) begin
					wdata = pick_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pos_q      <= '0;
			val_q      <= '0;
			pick_q     <= '0;
			pick_idx_q <= '0;
			r_ok_q     <= 1'b0;
			popped_q   <= '0;
			top_q      <= '0;
			status_q   <= STATUS_OK;
			m_tvalid   <= 1'b0;
			out_popped <= '0;
			out_top    <= '0;
			out_total  <= '0;
			out_status <= STATUS_OK;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			if (we && waddr == '0) begin
				top_q <= wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (in_cmd == CMD_PUSH) begin
							if (cnt_q == CW'(CAPACITY)) begin
								status_q <= STATUS_PUSH_FULL;
								state_q  <= ST_DONE;
							end else begin
								val_q   <= in_value;
								pos_q   <= AW'(cnt_q);
								cnt_q   <= cnt_q + CW'(1);
								state_q <= ST_PUSH_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= STATUS_POP_EMPTY;
								state_q  <= ST_DONE;
							end else begin
								cnt_q   <= cnt_q - CW'(1);
								state_q <= ST_POP_LD;
							end
						end
					end
				end
				ST_PUSH_RD: begin
					state_q <= (pos_q == '0) ? ST_DONE : ST_PUSH_CMP;
				end
				ST_PUSH_CMP: begin
					if (cmp_gt) begin
						pos_q   <= parent;
						state_q <= ST_PUSH_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_POP_LD: begin
					popped_q <= rdata_a;
					val_q    <= rdata_b;
					pos_q    <= '0;
					state_q  <= (cnt_q == '0) ? ST_DONE : ST_DN_RD;
				end
				ST_DN_RD: begin
					r_ok_q  <= r_ok;
					state_q <= l_ok ? ST_DN_CH : ST_DONE;
				end
				ST_DN_CH: begin
					if (r_ok_q && cmp_gt) begin
						pick_q     <= rdata_b;
						pick_idx_q <= r_addr;
					end else begin
						pick_q     <= rdata_a;
						pick_idx_q <= l_addr;
					end
					state_q <= ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (cmp_gt) begin
						pos_q   <= pick_idx_q;
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid   <= 1'b1;
						out_popped <= popped_q;
						out_top    <= (cnt_q == '0) ? '0 : top_q;
						out_total  <= TOTAL_W'(cnt_q);
						out_status <= status_q;
						popped_q   <= '0;
						status_q   <= STATUS_OK;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/binary_max_heap_queue_unit.sv
// channel | dir | tdata fields (lsb up)                                 | tuser
// s       | in  | value[31:0]                                           | cmd
// m       | out | popped_value[31:0] top_value[63:32] entry_total[70:64] | status[1:0]
//
// one request at a time, s_tready high only while idle; a new request waits until the last result is issued
// per request: a push climbs a level per compare until it reaches the root or stops below a larger parent,
// a pop moves the last entry to the root and descends until it stops above a leaf or has no child left,
// a refused request goes straight to its result; one store read and compare a step
// reset empties the heap at once, no clearing pass
// a result waiting on m_tready holds the unit in its final state until taken
module binary_max_heap_queue_unit #(
	parameter int CAPACITY = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,  // value
	input  logic [0:0]                   s_tuser,  // cmd
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bmhq_pkg::OUT_W-1:0]   m_tdata,  // popped_value, top_value, entry_total
	output logic [1:0]                   m_tuser   // status
);
	import bmhq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                     we;
	logic [AW-1:0]            waddr;
	logic signed [DATA_W-1:0] wdata;
	logic [AW-1:0]            raddr_a;
	logic [AW-1:0]            raddr_b;
	logic signed [DATA_W-1:0] rdata_a;
	logic signed [DATA_W-1:0] rdata_b;
	logic signed [DATA_W-1:0] cmp_lhs;
	logic signed [DATA_W-1:0] cmp_rhs;
	logic                     cmp_gt;
	logic signed [DATA_W-1:0] out_popped;
	logic signed [DATA_W-1:0] out_top;
	logic [TOTAL_W-1:0]       out_total;
	status_t                  out_status;

	bmhq_ctrl #(
		.CAPACITY(CAPACITY),
		.AW      (AW),
		.CW      (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.in_value  (s_tdata),
		.in_cmd    (s_tuser[0]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_popped(out_popped),
		.out_top   (out_top),
		.out_total (out_total),
		.out_status(out_status),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.cmp_lhs   (cmp_lhs),
		.cmp_rhs   (cmp_rhs),
		.cmp_gt    (cmp_gt)
	);

	bmhq_store #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	bmhq_cmp u_cmp (
		.lhs(cmp_lhs),
		.rhs(cmp_rhs),
		.gt (cmp_gt)
	);

	assign m_tdata = {{PAD_W{1'b0}}, out_total, out_top, out_popped};
	assign m_tuser = out_status;

endmodule

// File: sv/bmhq_checker.sv
module bmhq_checker #(
	parameter int CAPACITY = 64
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [bmhq_pkg::OUT_W-1:0] m_tdata,
	input logic [1:0]                 m_tuser
);
	import bmhq_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// every request occupies the unit past its accept cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken back to back");

	// refused pop reports an empty heap
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_POP_EMPTY |->
			m_tdata[63:0] == '0 && m_tdata[70:64] == '0)
		else $error("pop on empty heap with nonzero result");

	// refused push reports a full heap and no popped value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_PUSH_FULL |->
			m_tdata[70:64] == TOTAL_W'(CAPACITY) && m_tdata[31:0] == '0)
		else $error("push refused while not full");

	// empty heap shows no top value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[70:64] == '0 && CAPACITY < 128 |-> m_tdata[63:32] == '0)
		else $error("top value on empty heap");

endmodule

bind binary_max_heap_queue_unit bmhq_checker #(
	.CAPACITY(CAPACITY)
) u_bmhq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import bmhq_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		logic [31:0] popped;
		logic [31:0] top;
		logic [6:0]  total;
		status_t     status;
	} heap_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;
	logic [0:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;
	logic [1:0]         m_tuser;

	// predictor state
	logic signed [31:0] heap_mem [CAPACITY];
	int unsigned        heap_cnt;
	heap_result_t       result_q [$];

	int src_idle_pct;
	int snk_idle_pct;
	int rx_hold_req;
	int rx_hold_left;
	int err_cnt;
	int checked_cnt;
	int push_cnt;
	int pop_cnt;
	int full_cnt;
	int empty_cnt;
	int cycle_cnt;

	binary_max_heap_queue_unit #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic heap_result_t heap_apply(cmd_t op, logic signed [31:0] val);
		heap_result_t       res;
		logic signed [31:0] tmp;
		int unsigned        pos;
		int unsigned        up;
		int unsigned        lc;
		int unsigned        rc;
		int unsigned        best;
		res.popped = '0;
		res.status = STATUS_OK;
		if (op == CMD_PUSH) begin
			if (heap_cnt >= CAPACITY) begin
				res.status = STATUS_PUSH_FULL;
				full_cnt++;
			end else begin
				heap_mem[heap_cnt] = val;
				pos = heap_cnt;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (!(heap_mem[pos] > heap_mem[up]))
						break;
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[up];
					heap_mem[up] = tmp;
					pos = up;
				end
				heap_cnt++;
				push_cnt++;
			end
		end else begin
			if (heap_cnt == 0) begin
				res.status = STATUS_POP_EMPTY;
				empty_cnt++;
			end else begin
				res.popped = heap_mem[0];
				heap_mem[0] = heap_mem[heap_cnt - 1];
				heap_cnt--;
				pos = 0;
				while (pos < heap_cnt) begin
					lc = 2 * pos + 1;
					rc = lc + 1;
					best = pos;
					if (lc < heap_cnt && heap_mem[lc] > heap_mem[best])
						best = lc;
					if (rc < heap_cnt && heap_mem[rc] > heap_mem[best])
						best = rc;
					if (best == pos)
						break;
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[best];
					heap_mem[best] = tmp;
					pos = best;
				end
				pop_cnt++;
			end
		end
		res.top = (heap_cnt > 0) ? heap_mem[0] : '0;
		res.total = heap_cnt[6:0];
		return res;
	endfunction

	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return $urandom;
		else if (sel < 85)
			return 32'($signed($urandom_range(7)) - 4);
		else begin
			case ($urandom_range(3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
	endfunction

	// entered and left at a falling edge
	task automatic send_request(cmd_t op, logic [31:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		result_q.push_back(heap_apply(op, val));
		@(negedge clk);
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_request(CMD_POP, 32'h1234_5678);
		send_request(CMD_PUSH, 32'h7fff_ffff);
		send_request(CMD_PUSH, 32'h8000_0000);
		send_request(CMD_PUSH, 32'h0000_0000);
		send_request(CMD_PUSH, 32'hffff_ffff);
		send_request(CMD_PUSH, 32'd5);
		send_request(CMD_PUSH, 32'd5);
		send_request(CMD_PUSH, 32'd5);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_POP, 32'hffff_ffff);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_PUSH, 32'h8000_0000);
		send_request(CMD_PUSH, 32'h8000_0000);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_POP, 32'h0);
		send_request(CMD_POP, 32'h0);
	endtask

	task automatic test_fill_overflow();
		while (heap_cnt < CAPACITY)
			send_request(CMD_PUSH, pick_value());
		repeat (3)
			send_request(CMD_PUSH, pick_value());
		send_request(CMD_POP, pick_value());
		send_request(CMD_PUSH, pick_value());
		send_request(CMD_PUSH, pick_value());
		while (heap_cnt > 0)
			send_request(CMD_POP, pick_value());
		send_request(CMD_POP, pick_value());
	endtask

	// receiver holds off while requests keep coming
	task automatic test_receiver_hold();
		rx_hold_req = 300;
		repeat (10)
			send_request(cmd_t'($urandom_range(1)), pick_value());
	endtask

	// sender waits for every result before going on
	task automatic test_sender_drain();
		repeat (6)
			send_request(CMD_PUSH, pick_value());
		go_idle();
		while (result_q.size() != 0)
			@(negedge clk);
		@(negedge clk);
		repeat (6)
			send_request(cmd_t'($urandom_range(1)), pick_value());
	endtask

	task automatic test_random(int n);
		int push_pct;
		cmd_t op;
		push_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			op = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
			send_request(op, pick_value());
			if ($urandom_range(99) < 3)
				go_idle();
		end
	endtask

	always @(negedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				$error("result with no request pending: tdata %h tuser %h",
					m_tdata, m_tuser);
				err_cnt++;
			end else begin
				want = result_q.pop_front();
				checked_cnt++;
				if (m_tdata[31:0] !== want.popped) begin
					$error("popped_value: expected %0d, got %0d",
						$signed(want.popped), $signed(m_tdata[31:0]));
					err_cnt++;
				end
				if (m_tdata[63:32] !== want.top) begin
					$error("top_value: expected %0d, got %0d",
						$signed(want.top), $signed(m_tdata[63:32]));
					err_cnt++;
				end
				if (m_tdata[70:64] !== want.total) begin
					$error("entry_total: expected %0d, got %0d", want.total, m_tdata[70:64]);
					err_cnt++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
			result_q.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		heap_cnt     = 0;
		rx_hold_req  = 0;
		rx_hold_left = 0;
		err_cnt      = 0;
		checked_cnt  = 0;
		push_cnt     = 0;
		pop_cnt      = 0;
		full_cnt     = 0;
		empty_cnt    = 0;
		src_idle_pct = 29;
		snk_idle_pct = 76;
		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_fill_overflow();
		test_receiver_hold();
		test_random(250);

		src_idle_pct = 76;
		snk_idle_pct = 29;
		test_random(300);
		test_sender_drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random(250);

		go_idle();
		while (result_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT)
			@(posedge clk);

		$display("checked %0d results: %0d pushes, %0d pops",
			checked_cnt, push_cnt, pop_cnt);
		$display("%0d refused when full, %0d when empty", full_cnt, empty_cnt);
		$display("covered value extremes, ties, a full heap, long output stalls and three idle mixes");
		if (err_cnt == 0 && result_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
